// ===== rtl/core/horizon_dq_to_ab_reference_defines.svh =====
// Assertion macros shared by the checker of the horizon reference generator.
// No dependencies; clock aclk and reset aresetn must be visible where used.
`ifndef HORIZON_DQ_TO_AB_REFERENCE_DEFINES_SVH
`define HORIZON_DQ_TO_AB_REFERENCE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HDAB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hdab check failed");

// antecedent implies consequent in the next cycle
`define HDAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hdab check failed");

`endif

// ===== rtl/core/hdab_pkg.sv =====
// Package of the horizon d/q to alpha/beta reference generator.
// Constants, register indexes, CORDIC angle table and the step tag type.
package hdab_pkg;

    localparam int HORIZON = 8;
    localparam int ITERS   = 14;
    localparam int KW      = 6;
    localparam logic [KW-1:0] LAST_K = KW'(HORIZON - 1);
    localparam logic signed [18:0] CORDIC_GAIN = 19'sd39797;

    typedef enum logic [1:0] {
        REG_START_OFFSET = 2'd0,
        REG_HORIZON_STEP = 2'd1,
        REG_D_REFERENCE  = 2'd2,
        REG_Q_REFERENCE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic          vld;
        logic [KW-1:0] k;
        logic          last;
    } hdab_tag_t;

    // atan(2^-i) in 1/65536 turns, rounded
    function automatic logic [15:0] atan_turn(input int i);
        logic [15:0] r;
        case (i)
            0:       r = 16'd8192;
            1:       r = 16'd4836;
            2:       r = 16'd2555;
            3:       r = 16'd1297;
            4:       r = 16'd651;
            5:       r = 16'd326;
            6:       r = 16'd163;
            7:       r = 16'd81;
            8:       r = 16'd41;
            9:       r = 16'd20;
            10:      r = 16'd10;
            11:      r = 16'd5;
            12:      r = 16'd3;
            13:      r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/hdab_atan.sv =====
// Pipelined CORDIC vectoring atan2, one iteration per stage.
// Depends on hdab_pkg.
module hdab_atan (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic               out_vld,
    output logic [15:0]        angle
);
    localparam int N = hdab_pkg::ITERS;

    logic signed [20:0] x_reg [0:N];
    logic signed [20:0] y_reg [0:N];
    logic [15:0]        z_reg [0:N];
    logic               zero_reg [0:N];
    logic               vld_reg [0:N];

    logic signed [20:0] ax, bx;
    assign ax = 21'(a) <<< 2;
    assign bx = 21'(b) <<< 2;

    // pre-rotation into the right half plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
        if (en) begin
            zero_reg[0] <= (a == 16'sd0) && (b == 16'sd0);
            if (a[15]) begin
                x_reg[0] <= -ax;
                y_reg[0] <= -bx;
                z_reg[0] <= 16'h8000;
            end else begin
                x_reg[0] <= ax;
                y_reg[0] <= bx;
                z_reg[0] <= 16'h0000;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][20]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + hdab_pkg::atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - hdab_pkg::atan_turn(i);
                end
            end
        end
    end

    assign out_vld = vld_reg[N];
    assign angle   = zero_reg[N] ? 16'd0 : z_reg[N];
endmodule

// ===== rtl/core/hdab_sincos.sv =====
// Pipelined CORDIC rotation giving cos and sin in Q15, step tag carried along.
// Depends on hdab_pkg.
module hdab_sincos (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  hdab_pkg::hdab_tag_t tag_in,
    input  logic [15:0]         angle,
    output hdab_pkg::hdab_tag_t tag_out,
    output logic signed [16:0]  cos_q15,
    output logic signed [16:0]  sin_q15
);
    localparam int N = hdab_pkg::ITERS;

    hdab_pkg::hdab_tag_t tag_reg [0:N+1];
    logic signed [18:0]  x_reg [0:N];
    logic signed [18:0]  y_reg [0:N];
    logic signed [17:0]  z_reg [0:N];
    logic                neg_reg [0:N];
    logic signed [16:0]  c_reg, s_reg;

    logic signed [17:0] za;
    assign za = 18'(signed'(angle));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0].vld <= 1'b0;
        end else if (en) begin
            tag_reg[0].vld <= tag_in.vld;
        end
        if (en) begin
            tag_reg[0].k    <= tag_in.k;
            tag_reg[0].last <= tag_in.last;
            x_reg[0] <= hdab_pkg::CORDIC_GAIN;
            y_reg[0] <= 19'sd0;
            // fold into the right half, negate at the end
            if (za > 18'sd16384) begin
                z_reg[0]   <= za - 18'sd32768;
                neg_reg[0] <= 1'b1;
            end else if (za < -18'sd16384) begin
                z_reg[0]   <= za + 18'sd32768;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0]   <= za;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i+1].vld <= 1'b0;
            end else if (en) begin
                tag_reg[i+1].vld <= tag_reg[i].vld;
            end
            if (en) begin
                tag_reg[i+1].k    <= tag_reg[i].k;
                tag_reg[i+1].last <= tag_reg[i].last;
                neg_reg[i+1]      <= neg_reg[i];
                if (!z_reg[i][17]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 18'(hdab_pkg::atan_turn(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 18'(hdab_pkg::atan_turn(i));
                end
            end
        end
    end

    logic signed [18:0] xn, yn, xr, yr;
    assign xn = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign yn = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign xr = (xn + 19'sd1) >>> 1;
    assign yr = (yn + 19'sd1) >>> 1;

    // Q16 to Q15, round half up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[N+1].vld <= 1'b0;
        end else if (en) begin
            tag_reg[N+1].vld <= tag_reg[N].vld;
        end
        if (en) begin
            tag_reg[N+1].k    <= tag_reg[N].k;
            tag_reg[N+1].last <= tag_reg[N].last;
            c_reg <= xr[16:0];
            s_reg <= yr[16:0];
        end
    end

    assign tag_out = tag_reg[N+1];
    assign cos_q15 = c_reg;
    assign sin_q15 = s_reg;
endmodule

// ===== rtl/core/horizon_dq_to_ab_reference.sv =====
// Top level of the horizon d/q to alpha/beta reference generator.
// Depends on hdab_pkg, hdab_atan and hdab_sincos.
//
// Usage:
//  - s_ channel: one word per control sample, tdata = {beta_in, alpha_in}.
//  - m_ channel: HORIZON words per input word, tdata = {step_index,
//    beta_ref, alpha_ref}, tlast on the final step of the run.
//  - cfg_ port: plain writes, indexes 0..3 = start_offset, horizon_step,
//    d_reference, q_reference; write only while the block is idle.
//  - Path: an input word passes the atan2 pipeline, the sequencer register,
//    the sin/cos pipeline, the product register and the output register
//    before its first result leaves.
//  - Throughput: one result per cycle unless m_tready stalls the output;
//    the step sequencer, which issues one angle per cycle when not stalled,
//    sets this. The atan2 pipeline buffers further input words meanwhile.
//  - Stall: a low m_tready with a result waiting freezes every back-end
//    stage in place; nothing is lost or repeated. s_tready drops when the
//    atan2 pipeline holds a finished word the sequencer cannot take yet.
//  - Reset (aresetn low, synchronous): all valid bits clear, registers
//    return to start_offset = 0, horizon_step = 0, d = 12745, q = 30380.
module horizon_dq_to_ab_reference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // alpha_in[15:0], beta_in[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // alpha_ref[16:0], beta_ref[33:17], step_index[39:34]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    // configuration registers
    logic [15:0]        start_offset_reg, horizon_step_reg;
    logic signed [15:0] d_ref_reg, q_ref_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg <= 16'd0;
            horizon_step_reg <= 16'd0;
            d_ref_reg        <= 16'sd12745;
            q_ref_reg        <= 16'sd30380;
        end else if (cfg_wr_en) begin
            case (hdab_pkg::cfg_index_t'(cfg_index))
                hdab_pkg::REG_START_OFFSET: start_offset_reg <= cfg_wdata;
                hdab_pkg::REG_HORIZON_STEP: horizon_step_reg <= cfg_wdata;
                hdab_pkg::REG_D_REFERENCE:  d_ref_reg        <= signed'(cfg_wdata);
                hdab_pkg::REG_Q_REFERENCE:  q_ref_reg        <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // whole back end advances when the output register is free or taken
    logic ce;
    logic out_vld_reg;
    assign ce = !out_vld_reg || m_tready;

    // atan2 front end
    logic        atan_vld;
    logic [15:0] atan_angle;
    logic        seq_load, atan_en;

    hdab_atan u_atan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (atan_en),
        .in_vld  (s_tvalid),
        .a       (signed'(s_tdata[15:0])),
        .b       (signed'(s_tdata[31:16])),
        .out_vld (atan_vld),
        .angle   (atan_angle)
    );

    // step sequencer: one angle per cycle while ce is high, angle accumulates horizon_step
    hdab_pkg::hdab_tag_t seq_reg;
    logic [15:0]         ang_reg;
    logic                seq_done;

    assign seq_done = !seq_reg.vld || (seq_reg.k == hdab_pkg::LAST_K);
    assign seq_load = ce && seq_done && atan_vld;
    assign atan_en  = !atan_vld || seq_load;
    assign s_tready = atan_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg.vld <= 1'b0;
        end else if (ce) begin
            seq_reg.vld <= !seq_done || atan_vld;
        end
        if (ce) begin
            if (!seq_done) begin
                seq_reg.k    <= seq_reg.k + 1'b1;
                seq_reg.last <= (seq_reg.k + 1'b1) == hdab_pkg::LAST_K;
                ang_reg      <= ang_reg + horizon_step_reg;
            end else begin
                seq_reg.k    <= '0;
                seq_reg.last <= hdab_pkg::LAST_K == '0;
                ang_reg      <= atan_angle + start_offset_reg;
            end
        end
    end

    // sin/cos back end
    hdab_pkg::hdab_tag_t sc_tag;
    logic signed [16:0]  cos_v, sin_v;

    hdab_sincos u_sincos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (ce),
        .tag_in  (seq_reg),
        .angle   (ang_reg),
        .tag_out (sc_tag),
        .cos_q15 (cos_v),
        .sin_q15 (sin_v)
    );

    // products
    hdab_pkg::hdab_tag_t mul_tag_reg;
    logic signed [32:0]  cd_reg, sq_reg, sd_reg, cq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_tag_reg.vld <= 1'b0;
        end else if (ce) begin
            mul_tag_reg.vld <= sc_tag.vld;
        end
        if (ce) begin
            mul_tag_reg.k    <= sc_tag.k;
            mul_tag_reg.last <= sc_tag.last;
            cd_reg <= cos_v * d_ref_reg;
            sq_reg <= sin_v * q_ref_reg;
            sd_reg <= sin_v * d_ref_reg;
            cq_reg <= cos_v * q_ref_reg;
        end
    end

    // rotate, round half up, wrap to Q2.15
    logic signed [34:0] a_sum, b_sum;
    assign a_sum = 35'(cd_reg) - 35'(sq_reg) + 35'sd16384;
    assign b_sum = 35'(sd_reg) + 35'(cq_reg) + 35'sd16384;

    logic [39:0] data_reg;
    logic        last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= mul_tag_reg.vld;
        end
        if (ce) begin
            data_reg <= {mul_tag_reg.k, b_sum[31:15], a_sum[31:15]};
            last_reg <= mul_tag_reg.last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
endmodule

// ===== rtl/core/hdab_checker.sv =====
// Port-level checker of the horizon reference generator, bound to the top.
// Depends on hdab_pkg and horizon_dq_to_ab_reference_defines.svh.
`include "horizon_dq_to_ab_reference_defines.svh"

module hdab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    // stalled result word holds
    `HDAB_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // words of one run leave back to back
    `HDAB_ASSERT_NEXT(a_run_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid)
    // step index counts up inside a run
    `HDAB_ASSERT_NEXT(a_step_count, m_tvalid && m_tready && !m_tlast,
        m_tdata[39:34] == 6'($past(m_tdata[39:34]) + 6'd1))
    // final step index carries tlast
    `HDAB_ASSERT_SAME(a_last_flag, m_tvalid, m_tlast == (m_tdata[39:34] == hdab_pkg::LAST_K))
endmodule

bind horizon_dq_to_ab_reference hdab_checker u_hdab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
